### design/cgd_pkg.sv
// cgd_pkg: shared types, constants and register codes of the code page decoder
// used by every module of the decoder and by its channel interfaces
package cgd_pkg;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int UNIT_W   = 16;
   localparam int INDEX_W  = 15;
   localparam int CSR_IDX_W = 2;

   // full table address before the range check (max lead offset * trail count + column)
   localparam int LUT_ADDR_W = 17;

   localparam int TABLE_DEPTH_DEF = 32768;
   localparam int TRAIL_COUNT     = 190;

   // trail byte bands
   localparam logic [BYTE_W-1:0] TRAIL_LO_FIRST = 8'h40;
   localparam logic [BYTE_W-1:0] TRAIL_LO_LAST  = 8'h7E;
   localparam logic [BYTE_W-1:0] HIGH_FIRST     = 8'h80;
   localparam logic [BYTE_W-1:0] TRAIL_HI_LAST  = 8'hFE;
   localparam logic [BYTE_W-1:0] TRAIL_HI_BASE  = 8'd63;

   localparam logic [UNIT_W-1:0] REPL_UNIT = 16'hFFFD;

   // request actions
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_DECODE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEAD_FIRST = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEAD_LAST  = 2'd2;

   // reset values
   localparam logic              MODE_RESET       = 1'b1;
   localparam logic [BYTE_W-1:0] LEAD_FIRST_RESET = 8'h81;
   localparam logic [BYTE_W-1:0] LEAD_LAST_RESET  = 8'hFE;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic              mode;
      logic [BYTE_W-1:0] lead_first;
      logic [BYTE_W-1:0] lead_last;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              final_byte;
      logic              dbl_ok;   // trail column, lead range and address all valid
   } issue_type;

   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      logic              replaced;
      logic              run_last;
      logic              string_end;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } res_pair_type;

endpackage

### design/cgd_if.sv
// cgd channel interfaces: request, response and register write channels
// depends on cgd_pkg for field widths
interface cgd_req_if;
   import cgd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [INDEX_W-1:0]   table_index;
   logic [UNIT_W-1:0]    table_value;
   logic [BYTE_W-1:0]    data_byte;
   logic                 final_byte;

   modport source (output valid, action, table_index, table_value, data_byte, final_byte,
                   input ready);
   modport sink   (input valid, action, table_index, table_value, data_byte, final_byte,
                   output ready);
endinterface

interface cgd_rsp_if;
   import cgd_pkg::*;
   logic              valid;
   logic              ready;
   logic [UNIT_W-1:0] code_unit;
   logic              replaced;
   logic              run_last;
   logic              string_end;

   modport source (output valid, code_unit, replaced, run_last, string_end, input ready);
   modport sink   (input valid, code_unit, replaced, run_last, string_end, output ready);
endinterface

interface cgd_csr_if;
   import cgd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [BYTE_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### design/cgd_table_ram.sv
// cgd_table_ram: mapping table memory with one write and one read port, registered read data
// depends on cgd_pkg
module cgd_table_ram import cgd_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int TABLE_AW    = $clog2(TABLE_DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [TABLE_AW-1:0] wr_addr,
   input  logic [UNIT_W-1:0]   wr_data,
   input  logic                rd_en,
   input  logic [TABLE_AW-1:0] rd_addr,
   output logic [UNIT_W-1:0]   rd_data_ff
);

   logic [UNIT_W-1:0] table_mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

endmodule

### design/cgd_decode.sv
// cgd_decode: lookup stage; resolves one byte against the table read data
// and the pending lead state, producing up to two results. depends on cgd_pkg
module cgd_decode import cgd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              issue_valid,
   input  issue_type         issue,
   output logic              issue_ready,
   input  logic [UNIT_W-1:0] rd_data,
   input  logic              fifo_room,
   output logic [BYTE_W-1:0] lead_cand,
   output res_pair_type      push
);

   logic              s1_valid_ff, s1_valid_in;
   issue_type         s1_ff;
   logic              pending_ff, pending_in;
   logic [BYTE_W-1:0] held_ff, held_in;

   logic              go;
   logic              rd_zero;
   logic              hit;
   logic              b_high;
   logic              b_lead;
   logic              b_has;
   result_type        b_res;
   result_type        r0, r1;
   logic [1:0]        n;

   assign go          = s1_valid_ff && fifo_room;
   assign issue_ready = !s1_valid_ff || go;
   // held lead as it stands once the stage item resolves
   assign lead_cand   = s1_valid_ff ? s1_ff.data_byte : held_ff;

   always_comb begin
      rd_zero = (rd_data == '0);
      hit     = pending_ff && cfg.mode && s1_ff.dbl_ok && !rd_zero;
      b_high  = s1_ff.data_byte[BYTE_W-1];
      b_lead  = b_high && (s1_ff.data_byte >= cfg.lead_first)
                && (s1_ff.data_byte <= cfg.lead_last);

      b_res = '0;
      b_has = 1'b1;
      if (!b_high) begin
         b_res.code_unit = UNIT_W'(s1_ff.data_byte);
      end else if (cfg.mode) begin
         b_res.code_unit = REPL_UNIT;
         b_res.replaced  = 1'b1;
         // a lead is held unless the string ends here
         b_has = !(b_lead && !s1_ff.final_byte);
      end else if (rd_zero) begin
         b_res.code_unit = REPL_UNIT;
         b_res.replaced  = 1'b1;
      end else begin
         b_res.code_unit = rd_data;
      end

      r0 = '0;
      r1 = '0;
      if (hit) begin
         r0.code_unit = rd_data;
         n = 2'd1;
      end else if (pending_ff) begin
         r0.code_unit = REPL_UNIT;
         r0.replaced  = 1'b1;
         r1 = b_res;
         n = b_has ? 2'd2 : 2'd1;
      end else begin
         r0 = b_res;
         n = b_has ? 2'd1 : 2'd0;
      end

      if (n == 2'd2) begin
         r1.run_last   = 1'b1;
         r1.string_end = s1_ff.final_byte;
      end else begin
         r0.run_last   = 1'b1;
         r0.string_end = s1_ff.final_byte;
      end

      push.count  = go ? n : 2'd0;
      push.first  = r0;
      push.second = r1;

      pending_in = pending_ff;
      held_in    = held_ff;
      if (go) begin
         pending_in = !hit && cfg.mode && b_lead && !s1_ff.final_byte;
         held_in    = s1_ff.data_byte;
      end

      s1_valid_in = issue_valid || (s1_valid_ff && !go);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pending_ff  <= 1'b0;
         held_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         pending_ff  <= pending_in;
         held_ff     <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_valid) begin
         s1_ff <= issue;
      end
   end

endmodule

### design/cgd_result_fifo.sv
// cgd_result_fifo: small response queue taking up to two results a cycle
// depends on cgd_pkg
module cgd_result_fifo import cgd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  res_pair_type push,
   output logic         room,
   output logic         out_valid,
   input  logic         out_ready,
   output result_type   out_res
);

   result_type           fifo_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   head_ff, head_in;
   logic [FIFO_AW-1:0]   tail_ff, tail_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic [FIFO_AW-1:0]   tail_next;
   logic                 pop;

   assign out_valid = (count_ff != '0);
   assign out_res   = fifo_mem[head_ff];
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff <= FIFO_CW'(FIFO_DEPTH - 2));
   assign tail_next = tail_ff + FIFO_AW'(1);

   always_comb begin
      head_in  = head_ff + (pop ? FIFO_AW'(1) : FIFO_AW'(0));
      tail_in  = tail_ff + FIFO_AW'(push.count);
      count_in = count_ff + FIFO_CW'(push.count) - (pop ? FIFO_CW'(1) : FIFO_CW'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         fifo_mem[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         fifo_mem[tail_next] <= push.second;
      end
   end

endmodule

### design/codepage_to_unicode_decoder.sv
// codepage_to_unicode_decoder: one request per cycle while the result queue has
// room; a data byte's results reach the response port through the table read
// register, then the result queue; a request with two results hands them out in turn.
// each accepted request uses the table at most once: one read or one load write.
// reset clears the pending lead and the queue and loads the register defaults;
// the table itself is not cleared and must be loaded before use.
module codepage_to_unicode_decoder import cgd_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cgd_req_if.sink   req_port,
   cgd_rsp_if.source rsp_port,
   cgd_csr_if.sink   csr_port
);

   localparam int TABLE_AW = $clog2(TABLE_DEPTH);

   cfg_type               cfg_ff, cfg_in;
   logic                  accept;
   logic                  is_decode;
   logic [LUT_ADDR_W-1:0] load_idx;
   logic                  wr_en;
   logic                  rd_en;
   logic [TABLE_AW-1:0]   rd_addr;
   logic [UNIT_W-1:0]     rd_data;
   logic [BYTE_W-1:0]     lead_cand;
   logic [BYTE_W-1:0]     b;
   logic [BYTE_W-1:0]     col;
   logic                  col_ok;
   logic                  held_ok;
   logic [BYTE_W-1:0]     lead_off;
   logic [LUT_ADDR_W-1:0] lut_addr;
   logic                  addr_ok;
   issue_type             issue;
   logic                  issue_ready;
   logic                  fifo_room;
   res_pair_type          push;
   result_type            out_res;

   // register writes
   assign csr_port.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_port.valid) begin
         case (csr_port.index)
            REG_MODE:       cfg_in.mode       = csr_port.data[0];
            REG_LEAD_FIRST: cfg_in.lead_first = csr_port.data;
            REG_LEAD_LAST:  cfg_in.lead_last  = csr_port.data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode       <= MODE_RESET;
         cfg_ff.lead_first <= LEAD_FIRST_RESET;
         cfg_ff.lead_last  <= LEAD_LAST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request side and table address
   assign req_port.ready = issue_ready;
   assign accept    = req_port.valid && issue_ready;
   assign is_decode = (req_port.action == ACT_DECODE);
   assign b         = req_port.data_byte;
   assign load_idx  = LUT_ADDR_W'(req_port.table_index);
   assign wr_en     = accept && !is_decode && (load_idx < LUT_ADDR_W'(TABLE_DEPTH));

   always_comb begin
      col_ok = 1'b1;
      if ((b >= TRAIL_LO_FIRST) && (b <= TRAIL_LO_LAST)) begin
         col = b - TRAIL_LO_FIRST;
      end else if ((b >= HIGH_FIRST) && (b <= TRAIL_HI_LAST)) begin
         col = b - HIGH_FIRST + TRAIL_HI_BASE;
      end else begin
         col    = '0;
         col_ok = 1'b0;
      end
      // lead is the one left by the item ahead, if that one stays pending
      held_ok  = (lead_cand >= cfg_ff.lead_first) && (lead_cand <= cfg_ff.lead_last);
      lead_off = lead_cand - cfg_ff.lead_first;
      lut_addr = LUT_ADDR_W'(lead_off) * LUT_ADDR_W'(TRAIL_COUNT) + LUT_ADDR_W'(col);
      addr_ok  = (lut_addr < LUT_ADDR_W'(TABLE_DEPTH));

      issue.data_byte  = b;
      issue.final_byte = req_port.final_byte;
      issue.dbl_ok     = col_ok && held_ok && addr_ok;

      if (cfg_ff.mode) begin
         rd_addr = lut_addr[TABLE_AW-1:0];
         rd_en   = accept && is_decode && addr_ok;
      end else begin
         rd_addr = TABLE_AW'(b[BYTE_W-2:0]);
         rd_en   = accept && is_decode;
      end
   end

   cgd_table_ram #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TABLE_AW    (TABLE_AW)
   ) u_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (load_idx[TABLE_AW-1:0]),
      .wr_data    (req_port.table_value),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   cgd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .issue_valid (accept && is_decode),
      .issue       (issue),
      .issue_ready (issue_ready),
      .rd_data     (rd_data),
      .fifo_room   (fifo_room),
      .lead_cand   (lead_cand),
      .push        (push)
   );

   cgd_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (fifo_room),
      .out_valid (rsp_port.valid),
      .out_ready (rsp_port.ready),
      .out_res   (out_res)
   );

   assign rsp_port.code_unit  = out_res.code_unit;
   assign rsp_port.replaced   = out_res.replaced;
   assign rsp_port.run_last   = out_res.run_last;
   assign rsp_port.string_end = out_res.string_end;

endmodule
